// ===== rtl/sha256_pkg.sv =====
`timescale 1ns / 1ps
package sha256_pkg;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    typedef struct packed {
        logic load_word;
        logic start_block;
        logic round_step;
        logic finish_block;
        logic reset_chain;
        logic [5:0] index;
    } dp_cmd_t;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/sha256_dp.sv =====
`timescale 1ns / 1ps
module sha256_dp
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha256_pkg::dp_cmd_t   cmd,
    input  logic [31:0]           load_data,
    input  logic [2:0]            out_sel,
    output logic [31:0]           chain_out
);
    import sha256_pkg::*;

    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] w_cur;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;

    always_comb
    begin
        w_new = w_reg[0]
            + (ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3))
            + w_reg[9]
            + (ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10));
        w_cur = w_reg[0];
        t1 = v_reg[7] + (ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25))
            + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
            + ROUND_K[cmd.index] + w_cur;
        t2 = (ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22))
            + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        w_next = w_reg;
        v_next = v_reg;
        chain_next = chain_reg;
        if (cmd.load_word)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = load_data;
        end
        if (cmd.start_block)
        begin
            v_next = chain_reg;
        end
        if (cmd.round_step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = w_new;
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
        if (cmd.finish_block)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i] = chain_reg[i] + v_reg[i];
            end
        end
        if (cmd.reset_chain)
        begin
            chain_next = INIT_H;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= INIT_H;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        w_reg <= w_next;
    end

    assign chain_out = chain_reg[out_sel];

endmodule

// ===== rtl/sha256_ctrl.sv =====
`timescale 1ns / 1ps
module sha256_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_byte,
    input  logic                  s_present,
    input  logic                  s_end,
    output sha256_pkg::dp_cmd_t   cmd,
    output logic [31:0]           load_data,
    output logic [2:0]            out_sel,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  m_last
);
    import sha256_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_LOAD  = 6'b000100,
        S_ROUND = 6'b001000,
        S_FIN   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [5:0] fill_reg, fill_next;
    logic [60:0] total_reg, total_next;
    logic [5:0] idx_reg, idx_next;
    logic [2:0] osel_reg, osel_next;
    logic padding_reg, padding_next;
    logic pad_first_reg, pad_first_next;
    logic tail_reg, tail_next;
    logic [23:0] word_reg, word_next;
    logic [63:0] bit_len;
    logic [7:0] pad_val;
    logic [7:0] push_val;
    logic push;

    assign bit_len = {total_reg, 3'b000};

    always_comb
    begin
        if (pad_first_reg)
        begin
            pad_val = PAD_BYTE;
        end
        else if (tail_reg && fill_reg >= LEN_OFFSET)
        begin
            pad_val = bit_len[6'(63 - 8 * int'(fill_reg - LEN_OFFSET)) -: 8];
        end
        else
        begin
            pad_val = 8'h00;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        total_next = total_reg;
        idx_next = idx_reg;
        osel_next = osel_reg;
        padding_next = padding_reg;
        pad_first_next = pad_first_reg;
        tail_next = tail_reg;
        word_next = word_reg;
        cmd = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        m_last = 1'b0;
        push = 1'b0;
        push_val = s_byte;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_present)
                    begin
                        push = 1'b1;
                        total_next = total_reg + 61'd1;
                    end
                    if (s_end)
                    begin
                        padding_next = 1'b1;
                        pad_first_next = 1'b1;
                        if (!s_present || fill_reg != 6'd63)
                        begin
                            state_next = S_PAD;
                        end
                    end
                end
            end
            S_PAD:
            begin
                push = 1'b1;
                push_val = pad_val;
                pad_first_next = 1'b0;
                if (pad_first_reg && fill_reg < LEN_OFFSET)
                begin
                    tail_next = 1'b1;
                end
            end
            S_LOAD:
            begin
                state_next = S_ROUND;
                idx_next = 6'd0;
                cmd.start_block = 1'b1;
            end
            S_ROUND:
            begin
                cmd.round_step = 1'b1;
                cmd.index = idx_reg;
                idx_next = idx_reg + 6'd1;
                if (idx_reg == 6'd63)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish_block = 1'b1;
                if (padding_reg && tail_reg)
                begin
                    state_next = S_OUT;
                    osel_next = 3'd0;
                    padding_next = 1'b0;
                    tail_next = 1'b0;
                end
                else if (padding_reg)
                begin
                    state_next = S_PAD;
                    if (!pad_first_reg)
                    begin
                        tail_next = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
                m_last = (osel_reg == 3'd7);
                if (m_tready)
                begin
                    osel_next = osel_reg + 3'd1;
                    if (osel_reg == 3'd7)
                    begin
                        cmd.reset_chain = 1'b1;
                        total_next = '0;
                        fill_next = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        load_data = {word_reg, push_val};
        if (push)
        begin
            fill_next = fill_reg + 6'd1;
            word_next = {word_reg[15:0], push_val};
            if (fill_reg[1:0] == 2'b11)
            begin
                cmd.load_word = 1'b1;
            end
            if (fill_reg == 6'd63)
            begin
                state_next = S_LOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg <= '0;
            total_reg <= '0;
            idx_reg <= '0;
            osel_reg <= '0;
            padding_reg <= 1'b0;
            pad_first_reg <= 1'b0;
            tail_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            total_reg <= total_next;
            idx_reg <= idx_next;
            osel_reg <= osel_next;
            padding_reg <= padding_next;
            pad_first_reg <= pad_first_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_sel = osel_reg;

endmodule

// ===== rtl/sha256_message_hasher_top.sv =====
`timescale 1ns / 1ps
// Bytes are taken one per cycle until a block fills; each full block then goes through one load,
// 64 rounds on the single round unit and one chaining add, and no byte is taken meanwhile.
// End of message adds padding at one byte per cycle plus one or two block compressions, then
// the eight digest words, one per accepted item.
// Reset (rst_n low, asynchronous) loads the initial hash values and clears all counts.
module sha256_message_hasher_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // message_byte
    input  logic [1:0]  s_tuser,    // byte_present, end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // digest_word
    output logic        m_tlast
);
    import sha256_pkg::*;

    dp_cmd_t cmd;
    logic [31:0] load_data;
    logic [2:0] out_sel;

    sha256_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_byte    (s_tdata),
        .s_present (s_tuser[0]),
        .s_end     (s_tuser[1]),
        .cmd       (cmd),
        .load_data (load_data),
        .out_sel   (out_sel),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_last    (m_tlast)
    );

    sha256_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .load_data (load_data),
        .out_sel   (out_sel),
        .chain_out (m_tdata)
    );

endmodule

// ===== bench/tb_sha256_message_hasher_top.sv =====
`timescale 1ns / 1ps
module tb_sha256_message_hasher_top;

    import sha256_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } digest_item_t;

    typedef struct {
        logic [7:0]  data;
        logic        present;
        logic        eom;
        logic        typed;
        logic [31:0] first_word;
    } byte_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;

    logic [31:0]  chain_state [8];
    logic [7:0]   block_bytes [64];
    int unsigned  fill_count;
    logic [60:0]  length_bytes;
    digest_item_t digest_queue [$];
    byte_row_t    stim_rows [$];

    int  mismatch_count;
    int  digests_seen;
    bit  quiet_phase;
    bit  hold_receiver;

    sha256_message_hasher_top i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic clear_hash_state();
        for (int i = 0; i < 8; i++)
        begin
            chain_state[i] = INIT_H[i];
        end
        fill_count   = 0;
        length_bytes = '0;
    endtask

    task automatic compress_buffer();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
        end
        for (int i = 16; i < 64; i++)
        begin
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        for (int i = 0; i < 8; i++)
        begin
            v[i] = chain_state[i];
        end
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            chain_state[i] = chain_state[i] + v[i];
        end
    endtask

    task automatic append_byte(input logic [7:0] b);
        block_bytes[fill_count[5:0]] = b;
        fill_count++;
        if (fill_count == 64)
        begin
            compress_buffer();
            fill_count = 0;
        end
    endtask

    task automatic predict_digest(input logic [7:0] data, input logic present, input logic eom);
        logic [63:0] bit_length;
        digest_item_t item;
        if (present)
        begin
            append_byte(data);
            length_bytes = length_bytes + 61'd1;
        end
        if (eom)
        begin
            bit_length = {length_bytes, 3'b000};
            append_byte(PAD_BYTE);
            while (fill_count != LEN_OFFSET)
            begin
                append_byte(8'h00);
            end
            for (int i = 0; i < 8; i++)
            begin
                append_byte(bit_length[63 - 8*i -: 8]);
            end
            for (int i = 0; i < 8; i++)
            begin
                item = '{word: chain_state[i], last: (i == 7)};
                digest_queue = {digest_queue, item};
            end
            clear_hash_state();
        end
    endtask

    task automatic add_row(input logic [7:0] d, input logic p, input logic e,
                           input logic typed = 0, input logic [31:0] w0 = '0);
        byte_row_t row;
        row = '{data: d, present: p, eom: e, typed: typed, first_word: w0};
        stim_rows = {stim_rows, row};
    endtask

    task automatic add_message(input int len, input bit with_idle);
        for (int i = 0; i < len; i++)
        begin
            if (with_idle && $urandom_range(0, 9) == 0)
            begin
                add_row(8'($urandom), 1'b0, 1'b0);
            end
            if (i == len - 1 && $urandom_range(0, 1))
            begin
                add_row(8'($urandom), 1'b1, 1'b1);
                return;
            end
            add_row(8'($urandom), 1'b1, 1'b0);
        end
        add_row(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic send_row(input byte_row_t row);
        s_tvalid <= 1'b1;
        s_tdata  <= row.data;
        s_tuser  <= {row.eom, row.present};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predict_digest(row.data, row.present, row.eom);
        if (row.typed && digest_queue.size() >= 8
            && digest_queue[digest_queue.size() - 8].word != row.first_word)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("predictor first word mismatch: expected %h got %h",
                         row.first_word, digest_queue[digest_queue.size() - 8].word);
            end
        end
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (digest_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected digest item: word %h last %b", m_tdata, m_tlast);
                end
            end
            else
            begin
                if (m_tdata !== digest_queue[0].word || m_tlast !== digest_queue[0].last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("digest mismatch: expected %h/%b got %h/%b",
                                 digest_queue[0].word, digest_queue[0].last, m_tdata, m_tlast);
                    end
                end
                void'(digest_queue.pop_front());
                digests_seen++;
            end
        end
    end

    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_receiver)
            begin
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_receiver = 0;
            end
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int sent;
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        mismatch_count = 0;
        digests_seen   = 0;
        quiet_phase    = 0;
        hold_receiver  = 0;
        sent           = 0;
        clear_hash_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: the empty message, "abc", a lone idle item and extreme bytes.
        add_row(8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442);
        add_row(8'h61, 1'b1, 1'b0);
        add_row(8'h62, 1'b1, 1'b0);
        add_row(8'hff, 1'b0, 1'b0);
        add_row(8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf);
        add_row(8'h00, 1'b1, 1'b0);
        add_row(8'hff, 1'b1, 1'b0);
        add_row(8'haa, 1'b0, 1'b0);
        add_row(8'h55, 1'b1, 1'b1);
        add_row(8'hff, 1'b1, 1'b1);
        add_row(8'h00, 1'b0, 1'b1);
        foreach (stim_rows[i])
        begin
            send_row(stim_rows[i]);
        end
        sent += stim_rows.size();
        stim_rows.delete();

        // Lengths around the padding boundaries: 55, 56, 63, 64 bytes.
        add_message(55, 0);
        add_message(56, 0);
        add_message(63, 0);
        add_message(64, 0);
        foreach (stim_rows[i])
        begin
            send_row(stim_rows[i]);
        end
        sent += stim_rows.size();
        stim_rows.delete();

        s_tvalid <= 1'b0;
        wait (digest_queue.size() == 0);
        @(posedge clk);

        hold_receiver = 1;
        while (sent < 430)
        begin
            if (sent > 330)
            begin
                quiet_phase = 1;
            end
            add_message($urandom_range(0, 9) == 0 ? $urandom_range(60, 130)
                                                  : $urandom_range(0, 12), 1);
            foreach (stim_rows[i])
            begin
                send_row(stim_rows[i]);
            end
            sent += stim_rows.size();
            stim_rows.delete();
        end
        s_tvalid <= 1'b0;
        wait (digest_queue.size() == 0);
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && digest_queue.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sha256_pkg.sv
rtl/sha256_dp.sv
rtl/sha256_ctrl.sv
rtl/sha256_message_hasher_top.sv
bench/tb_sha256_message_hasher_top.sv
